// ===== hw/rtl/beat_detector_energy_onset_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the beat detector
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BEAT_DETECTOR_ENERGY_ONSET_ASSERT_SVH
`define BEAT_DETECTOR_ENERGY_ONSET_ASSERT_SVH

// consequent holds in the same cycle
`define BDEO_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the next cycle
`define BDEO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bdeo_pkg.sv =====
// ----------------------------------------------------------------------------
// bdeo_pkg
// Types and constants of the energy onset beat detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdeo_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CNT_W    = 16;
    localparam int ENERGY_W = 19;
    localparam int THR_W    = 16;
    localparam int REFR_W   = 10;
    localparam int MINV_W   = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;
    localparam logic [CNT_W-1:0]    CNT_MAX    = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRACT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VOTES = 2'd3;

    localparam logic [THR_W-1:0]    RST_PEAK_THR  = 16'd945;
    localparam logic [ENERGY_W-1:0] RST_NOISE     = 19'd301;
    localparam logic [REFR_W-1:0]   RST_REFRACT   = 10'd20;
    localparam logic [MINV_W-1:0]   RST_MIN_VOTES = 3'd4;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENERGY,
        S_UPDATE,
        S_SEARCH,
        S_FINISH
    } t_state;

endpackage

// ===== hw/rtl/beat_detector_energy_onset.sv =====
// Items are taken one at a time: o_in_stall is high outside S_IDLE. A clear item goes
// to S_FINISH; a sample item runs the window through the shared adder (S_ENERGY),
// then S_UPDATE, an onset search over the single read port of the energy ring while
// inside a beat (S_SEARCH), and S_FINISH.
// Reset (synchronous, active low): counters, flags and window cleared, ring entries
// marked empty (read as zero), registers back to their defaults.
// ----------------------------------------------------------------------------
// beat_detector_energy_onset
// Window energy, vote based peak start, backward onset search and end report.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "beat_detector_energy_onset_assert.svh"

module beat_detector_energy_onset #(
    parameter int WINDOW_LEN   = 5,
    parameter int ENERGY_DEPTH = 20,
    parameter int VOTE_LEN     = 6
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // item input
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_kind,
    input  logic signed [bdeo_pkg::SAMPLE_W-1:0] i_sample,
    // result output
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_peak_found,
    output logic [bdeo_pkg::CNT_W-1:0]         o_peak_index,
    output logic                               o_onset_found,
    output logic [bdeo_pkg::CNT_W-1:0]         o_onset_index,
    output logic                               o_end_found,
    output logic [bdeo_pkg::CNT_W-1:0]         o_end_index,
    output logic [bdeo_pkg::CNT_W-1:0]         o_beat_count,
    output logic [bdeo_pkg::ENERGY_W-1:0]      o_energy,
    // configuration
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bdeo_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bdeo_pkg::ENERGY_W-1:0]      i_cfg_data
);

    localparam int CW    = $clog2(WINDOW_LEN + 1);
    localparam int RUN_W = bdeo_pkg::SAMPLE_W + 1 + $clog2(WINDOW_LEN);
    localparam int ACC_W = 20 + 2 * $clog2(WINDOW_LEN);
    localparam int HW    = $clog2(ENERGY_DEPTH);
    localparam int JW    = $clog2(ENERGY_DEPTH + 1);
    localparam int VCW   = $clog2(VOTE_LEN + 1) + 1;

    localparam int CW_ = bdeo_pkg::CNT_W;

    // configuration
    logic [bdeo_pkg::THR_W-1:0]    r_peak_thr;
    logic [bdeo_pkg::ENERGY_W-1:0] r_noise;
    logic [bdeo_pkg::REFR_W-1:0]   r_refract;
    logic [bdeo_pkg::MINV_W-1:0]   r_min_votes;

    // sequencer
    bdeo_pkg::t_state r_state, n_state;
    logic             in_accept, out_free, out_load, ring_we;

    // detector state
    logic signed [bdeo_pkg::SAMPLE_W-1:0] r_win [WINDOW_LEN];
    logic [HW-1:0]           r_head;
    logic [ENERGY_DEPTH-1:0] r_ring_vld;
    logic [VOTE_LEN-1:0]     r_votes;
    logic [CW_-1:0]          r_sc, r_beats, r_since_peak, r_since_fall;
    logic                    r_in_beat, r_seek;

    // work registers
    logic [CW-1:0]           r_cnt;
    logic signed [RUN_W-1:0] r_run;
    logic [ACC_W-1:0]        r_acc;
    logic [bdeo_pkg::ENERGY_W-1:0] r_energy;
    logic [JW-1:0]           r_j, r_k;
    logic                    r_chk;
    logic                    r_peak_p, r_onset_p, r_end_p;

    // energy ring
    logic [bdeo_pkg::ENERGY_W-1:0] r_ring [ENERGY_DEPTH];
    logic [bdeo_pkg::ENERGY_W-1:0] r_rd;
    logic                          r_rd_vld;

    // output register
    logic                          r_out_vld;
    logic                          r_o_peak, r_o_onset, r_o_end;
    logic [CW_-1:0]                r_o_peak_idx, r_o_onset_idx, r_o_end_idx, r_o_beats;
    logic [bdeo_pkg::ENERGY_W-1:0] r_o_energy;

    // combinational datapath
    logic [RUN_W-1:0]              run_abs;
    logic [bdeo_pkg::ENERGY_W-1:0] energy_sat;
    logic [HW-1:0]                 head_inc;
    logic [CW_-1:0]                sp_inc, sf_inc;
    logic [bdeo_pkg::SAMPLE_W:0]   mag;
    logic                          vote;
    logic [VOTE_LEN-1:0]           votes_nxt;
    logic [VCW-1:0]                vote_cnt;
    logic                          peak_cond, start_peak, fall;
    logic                          in_beat_nxt, seek_tmp, end_hit;
    logic [JW:0]                   rd_diff;
    logic [HW-1:0]                 rd_addr;
    logic [bdeo_pkg::ENERGY_W-1:0] rd_val;
    logic                          hit, last_j;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak_thr  <= bdeo_pkg::RST_PEAK_THR;
            r_noise     <= bdeo_pkg::RST_NOISE;
            r_refract   <= bdeo_pkg::RST_REFRACT;
            r_min_votes <= bdeo_pkg::RST_MIN_VOTES;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bdeo_pkg::CFG_PEAK_THR:  r_peak_thr  <= i_cfg_data[bdeo_pkg::THR_W-1:0];
                bdeo_pkg::CFG_NOISE:     r_noise     <= i_cfg_data;
                bdeo_pkg::CFG_REFRACT:   r_refract   <= i_cfg_data[bdeo_pkg::REFR_W-1:0];
                bdeo_pkg::CFG_MIN_VOTES: r_min_votes <= i_cfg_data[bdeo_pkg::MINV_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- datapath logic ----------------
    always_comb begin
        run_abs    = r_run[RUN_W-1] ? RUN_W'(-r_run) : RUN_W'(r_run);
        energy_sat = (r_acc > ACC_W'(bdeo_pkg::ENERGY_MAX)) ? bdeo_pkg::ENERGY_MAX
                                                           : r_acc[bdeo_pkg::ENERGY_W-1:0];
        head_inc   = (r_head == HW'(ENERGY_DEPTH - 1)) ? '0 : r_head + 1'b1;
        sp_inc     = (r_since_peak == bdeo_pkg::CNT_MAX) ? r_since_peak : r_since_peak + 1'b1;
        sf_inc     = (r_since_fall == bdeo_pkg::CNT_MAX) ? r_since_fall : r_since_fall + 1'b1;

        mag  = r_win[0][bdeo_pkg::SAMPLE_W-1] ? -(bdeo_pkg::SAMPLE_W + 1)'(r_win[0])
                                              :  (bdeo_pkg::SAMPLE_W + 1)'(r_win[0]);
        vote = mag > (bdeo_pkg::SAMPLE_W + 1)'(r_peak_thr);
        votes_nxt = (r_votes << 1) | VOTE_LEN'(vote);
        vote_cnt  = '0;
        for (int i = 0; i < VOTE_LEN; i++) begin
            vote_cnt = vote_cnt + VCW'(votes_nxt[i]);
        end

        peak_cond  = (vote_cnt > VCW'(r_min_votes)) && (sp_inc >= sf_inc)
                     && (sf_inc > CW_'(r_refract));
        start_peak = peak_cond && !r_in_beat;
        fall       = !peak_cond && r_in_beat;
        in_beat_nxt = start_peak ? 1'b1 : (fall ? 1'b0 : r_in_beat);
        seek_tmp   = r_seek || in_beat_nxt;
        end_hit    = seek_tmp && (energy_sat < r_noise);

        rd_diff = (JW + 1)'(r_head) - (JW + 1)'(r_j);
        if (rd_diff[JW]) begin
            rd_diff = rd_diff + (JW + 1)'(ENERGY_DEPTH);
        end
        rd_addr = rd_diff[HW-1:0];
        rd_val  = r_rd_vld ? r_rd : '0;
        hit     = r_chk && (rd_val < r_noise);
        last_j  = (r_j == JW'(ENERGY_DEPTH));
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            bdeo_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_state = (i_kind == bdeo_pkg::KIND_CLEAR) ? bdeo_pkg::S_FINISH
                                                               : bdeo_pkg::S_ENERGY;
                end
            end
            bdeo_pkg::S_ENERGY: begin
                if (r_cnt == CW'(WINDOW_LEN - 1)) begin
                    n_state = bdeo_pkg::S_UPDATE;
                end
            end
            bdeo_pkg::S_UPDATE: begin
                n_state = (in_beat_nxt && (energy_sat >= r_noise)) ? bdeo_pkg::S_SEARCH
                                                                    : bdeo_pkg::S_FINISH;
            end
            bdeo_pkg::S_SEARCH: begin
                if (hit || last_j) begin
                    n_state = bdeo_pkg::S_FINISH;
                end
            end
            bdeo_pkg::S_FINISH: begin
                if (out_free) begin
                    n_state = bdeo_pkg::S_IDLE;
                end
            end
            default: n_state = bdeo_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != bdeo_pkg::S_IDLE);
        in_accept  = i_in_valid && !o_in_stall;
        out_free   = !r_out_vld || !i_out_stall;
        out_load   = (r_state == bdeo_pkg::S_FINISH) && out_free;
        ring_we    = (r_state == bdeo_pkg::S_UPDATE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bdeo_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- detector state and work registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                r_win[i] <= '0;
            end
            r_head       <= '0;
            r_ring_vld   <= '0;
            r_votes      <= '0;
            r_sc         <= '0;
            r_beats      <= '0;
            r_since_peak <= '0;
            r_since_fall <= '0;
            r_in_beat    <= 1'b0;
            r_seek       <= 1'b0;
            r_cnt        <= '0;
            r_j          <= '0;
            r_k          <= '0;
            r_chk        <= 1'b0;
            r_peak_p     <= 1'b0;
            r_onset_p    <= 1'b0;
            r_end_p      <= 1'b0;
        end else begin
            case (r_state)
                bdeo_pkg::S_IDLE: begin
                    if (in_accept) begin
                        r_peak_p  <= 1'b0;
                        r_onset_p <= 1'b0;
                        r_end_p   <= 1'b0;
                        r_cnt     <= '0;
                        if (i_kind == bdeo_pkg::KIND_CLEAR) begin
                            r_sc    <= '0;
                            r_beats <= '0;
                        end else begin
                            r_sc <= r_sc + 1'b1;
                            for (int i = WINDOW_LEN - 1; i > 0; i--) begin
                                r_win[i] <= r_win[i-1];
                            end
                            r_win[0] <= i_sample;
                        end
                    end
                end
                bdeo_pkg::S_ENERGY: begin
                    // window rotates once around, tap 0 feeds the adder
                    for (int i = 0; i < WINDOW_LEN - 1; i++) begin
                        r_win[i] <= r_win[i+1];
                    end
                    r_win[WINDOW_LEN-1] <= r_win[0];
                    r_cnt <= r_cnt + 1'b1;
                end
                bdeo_pkg::S_UPDATE: begin
                    r_head            <= head_inc;
                    r_ring_vld[head_inc] <= 1'b1;
                    r_votes           <= votes_nxt;
                    r_since_peak      <= start_peak ? '0 : sp_inc;
                    r_since_fall      <= fall ? '0 : sf_inc;
                    r_in_beat         <= in_beat_nxt;
                    r_seek            <= seek_tmp && !end_hit;
                    r_peak_p          <= start_peak;
                    r_onset_p         <= in_beat_nxt;
                    r_end_p           <= end_hit;
                    if (end_hit) begin
                        r_beats <= r_beats + 1'b1;
                    end
                    r_k   <= JW'(ENERGY_DEPTH);
                    r_j   <= JW'(1);
                    r_chk <= 1'b0;
                end
                bdeo_pkg::S_SEARCH: begin
                    if (hit) begin
                        r_k <= r_j - 1'b1;
                    end else if (last_j) begin
                        r_k <= JW'(ENERGY_DEPTH);
                    end else begin
                        r_j   <= r_j + 1'b1;
                        r_chk <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // prefix sum and magnitude accumulator, payload only
    always_ff @(posedge i_clk) begin
        if (r_state == bdeo_pkg::S_ENERGY) begin
            if (r_cnt == '0) begin
                r_run <= RUN_W'(r_win[0]);
                r_acc <= '0;
            end else begin
                r_run <= r_run + RUN_W'(r_win[0]);
                r_acc <= r_acc + ACC_W'(run_abs);
            end
        end
        if (in_accept && (i_kind == bdeo_pkg::KIND_CLEAR)) begin
            r_energy <= '0;
        end else if (r_state == bdeo_pkg::S_UPDATE) begin
            r_energy <= energy_sat;
        end
    end

    // energy ring, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[head_inc] <= energy_sat;
        end
        r_rd     <= r_ring[rd_addr];
        r_rd_vld <= r_ring_vld[rd_addr];
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_peak      <= r_peak_p;
            r_o_onset     <= r_onset_p;
            r_o_end       <= r_end_p;
            r_o_peak_idx  <= r_peak_p ? r_sc : '0;
            r_o_onset_idx <= r_onset_p ? (r_sc - CW_'(r_k) - CW_'(WINDOW_LEN)) : '0;
            r_o_end_idx   <= r_end_p ? (r_sc + CW_'(WINDOW_LEN)) : '0;
            r_o_beats     <= r_beats;
            r_o_energy    <= r_energy;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_peak_found  = r_o_peak;
    assign o_peak_index  = r_o_peak_idx;
    assign o_onset_found = r_o_onset;
    assign o_onset_index = r_o_onset_idx;
    assign o_end_found   = r_o_end;
    assign o_end_index   = r_o_end_idx;
    assign o_beat_count  = r_o_beats;
    assign o_energy      = r_o_energy;

    // ---------------- assertions ----------------
    `BDEO_ASSERT_NEXT(a_busy_after_accept, in_accept, r_state != bdeo_pkg::S_IDLE, "idle after accept")
    `BDEO_ASSERT_NOW(a_search_range, r_state == bdeo_pkg::S_SEARCH, (r_j >= JW'(1)) && (r_j <= JW'(ENERGY_DEPTH)), "search index out of range")
    `BDEO_ASSERT_NOW(a_onset_k_range, out_load && r_onset_p, (r_k >= JW'(1)) && (r_k <= JW'(ENERGY_DEPTH)), "onset distance out of range")
    `BDEO_ASSERT_NOW(a_out_from_finish, $rose(o_out_valid), $past(r_state) == bdeo_pkg::S_FINISH, "result not from finish")

endmodule

// ===== tb/beat_detector_energy_onset_tb.sv =====
// ----------------------------------------------------------------------------
// beat_detector_energy_onset_tb
// Self-checking bench for the energy onset beat detector. A shadow model
// predicts each result at item acceptance and a monitor compares results in
// order. Runs directed items, random burst/quiet streams across register
// settings, an output hold-off, and a stretch with votes disabled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module beat_detector_energy_onset_tb;

    localparam int SAMPLE_W  = bdeo_pkg::SAMPLE_W;
    localparam int CNT_W     = bdeo_pkg::CNT_W;
    localparam int ENERGY_W  = bdeo_pkg::ENERGY_W;
    localparam int THR_W     = bdeo_pkg::THR_W;
    localparam int REFR_W    = bdeo_pkg::REFR_W;
    localparam int MINV_W    = bdeo_pkg::MINV_W;
    localparam int CFG_IDX_W = bdeo_pkg::CFG_IDX_W;

    localparam int WIN_LEN         = 5;
    localparam int RING_DEPTH      = 20;
    localparam int VOTE_DEPTH      = 6;
    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 9;
    localparam int SETTLE_CYCLES   = WIN_LEN + RING_DEPTH + 15;
    localparam int HOLD_LEN        = 300;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int MAX_PRINTS      = 100;
    localparam int RANDOM_ITEMS    = 80;
    localparam int QUIET_RUN_ITEMS = 40;

    typedef struct packed {
        logic                peak_found;
        logic [CNT_W-1:0]    peak_index;
        logic                onset_found;
        logic [CNT_W-1:0]    onset_index;
        logic                end_found;
        logic [CNT_W-1:0]    end_index;
        logic [CNT_W-1:0]    beat_count;
        logic [ENERGY_W-1:0] energy;
    } t_beat_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic                       i_kind = bdeo_pkg::KIND_SAMPLE;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic                       o_peak_found;
    logic [CNT_W-1:0]           o_peak_index;
    logic                       o_onset_found;
    logic [CNT_W-1:0]           o_onset_index;
    logic                       o_end_found;
    logic [CNT_W-1:0]           o_end_index;
    logic [CNT_W-1:0]           o_beat_count;
    logic [ENERGY_W-1:0]        o_energy;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [ENERGY_W-1:0]        i_cfg_data = '0;

    beat_detector_energy_onset #(
        .WINDOW_LEN  (WIN_LEN),
        .ENERGY_DEPTH(RING_DEPTH),
        .VOTE_LEN    (VOTE_DEPTH)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_sample     (i_sample),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_peak_found (o_peak_found),
        .o_peak_index (o_peak_index),
        .o_onset_found(o_onset_found),
        .o_onset_index(o_onset_index),
        .o_end_found  (o_end_found),
        .o_end_index  (o_end_index),
        .o_beat_count (o_beat_count),
        .o_energy     (o_energy),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // shadow registers and state
    logic [THR_W-1:0]           thr_reg;
    logic [ENERGY_W-1:0]        noise_reg;
    logic [REFR_W-1:0]          refract_reg;
    logic [MINV_W-1:0]          min_votes_reg;
    logic signed [SAMPLE_W-1:0] window [WIN_LEN];
    logic [ENERGY_W-1:0]        energy_hist [RING_DEPTH];
    int                         hist_head;
    logic [VOTE_DEPTH-1:0]      vote_bits;
    int                         vote_pos;
    logic [CNT_W-1:0]           n_samples;
    logic [CNT_W-1:0]           n_beats;
    logic [CNT_W-1:0]           since_pk;
    logic [CNT_W-1:0]           since_fl;
    bit                         beat_on;
    bit                         end_pending;

    t_beat_result expected_beats [$];
    t_beat_result chk_want;
    int           fail_cnt = 0;
    int           quiet_cycles = 0;
    bit           gaps_on = 1'b1;
    bit           stalls_on = 1'b1;
    int           hold_trig = 0;
    int           hold_seen = 0;
    int           hold_left = 0;
    int           stall_left = 0;
    bit           in_burst = 1'b0;
    int           seg_left = 0;

    function automatic void reset_shadow();
        thr_reg       = bdeo_pkg::RST_PEAK_THR;
        noise_reg     = bdeo_pkg::RST_NOISE;
        refract_reg   = bdeo_pkg::RST_REFRACT;
        min_votes_reg = bdeo_pkg::RST_MIN_VOTES;
        foreach (window[i]) window[i] = '0;
        foreach (energy_hist[i]) energy_hist[i] = '0;
        hist_head   = 0;
        vote_bits   = '0;
        vote_pos    = 0;
        n_samples   = '0;
        n_beats     = '0;
        since_pk    = '0;
        since_fl    = '0;
        beat_on     = 1'b0;
        end_pending = 1'b0;
    endfunction

    function automatic t_beat_result predict_beat(logic kind, logic [SAMPLE_W-1:0] raw);
        t_beat_result res;
        longint       run;
        longint       acc;
        logic [ENERGY_W-1:0] nrg;
        int           smag;
        int           n_votes;
        int           k;
        res = '0;
        if (kind == bdeo_pkg::KIND_CLEAR) begin
            n_samples = '0;
            n_beats   = '0;
            return res;
        end
        n_samples = n_samples + 1'b1;
        for (int i = WIN_LEN - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = raw;
        run = 0;
        acc = 0;
        for (int i = 0; i < WIN_LEN; i++) begin
            run += window[i];
            acc += (run < 0) ? -run : run;
        end
        acc -= (run < 0) ? -run : run;
        nrg = (acc > longint'(bdeo_pkg::ENERGY_MAX)) ? bdeo_pkg::ENERGY_MAX
                                                     : acc[ENERGY_W-1:0];
        hist_head = (hist_head + 1) % RING_DEPTH;
        energy_hist[hist_head] = nrg;
        if (since_pk != bdeo_pkg::CNT_MAX) since_pk = since_pk + 1'b1;
        if (since_fl != bdeo_pkg::CNT_MAX) since_fl = since_fl + 1'b1;

        vote_pos = (vote_pos + 1) % VOTE_DEPTH;
        smag = $signed(raw);
        if (smag < 0) smag = -smag;
        vote_bits[vote_pos] = (smag > int'(thr_reg));
        n_votes = $countones(vote_bits);

        if (n_votes > int'(min_votes_reg) && since_pk >= since_fl
                && since_fl > CNT_W'(refract_reg)) begin
            if (!beat_on) begin
                since_pk       = '0;
                beat_on        = 1'b1;
                res.peak_found = 1'b1;
                res.peak_index = n_samples;
            end
        end else if (beat_on) begin
            since_fl = '0;
            beat_on  = 1'b0;
        end

        if (beat_on) begin
            k = RING_DEPTH;
            end_pending = 1'b1;
            if (energy_hist[hist_head] >= noise_reg) begin
                for (int j = 1; j < RING_DEPTH; j++) begin
                    if (k == RING_DEPTH &&
                            energy_hist[(hist_head + RING_DEPTH - j) % RING_DEPTH] < noise_reg)
                        k = j;
                end
            end
            res.onset_found = 1'b1;
            res.onset_index = n_samples - CNT_W'(k) - CNT_W'(WIN_LEN);
        end

        if (end_pending && energy_hist[hist_head] < noise_reg) begin
            res.end_found = 1'b1;
            res.end_index = n_samples + CNT_W'(WIN_LEN);
            n_beats       = n_beats + 1'b1;
            end_pending   = 1'b0;
        end
        res.beat_count = n_beats;
        res.energy     = nrg;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        fail_cnt++;
        if (fail_cnt <= MAX_PRINTS)
            $display("mismatch %s: got %0d expected %0d at %0t ns", what, got, want, $time);
    endtask

    task automatic check_field(string what, longint got, longint want);
        if (got != want) report_mismatch(what, got, want);
    endtask

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_beats.size() == 0) begin
                report_mismatch("unexpected result, energy", o_energy, 0);
            end else begin
                chk_want = expected_beats.pop_front();
                check_field("peak_found", o_peak_found, chk_want.peak_found);
                check_field("peak_index", o_peak_index, chk_want.peak_index);
                check_field("onset_found", o_onset_found, chk_want.onset_found);
                check_field("onset_index", o_onset_index, chk_want.onset_index);
                check_field("end_found", o_end_found, chk_want.end_found);
                check_field("end_index", o_end_index, chk_want.end_index);
                check_field("beat_count", o_beat_count, chk_want.beat_count);
                check_field("energy", o_energy, chk_want.energy);
            end
        end
    end

    // receiver stall, with an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_trig != hold_seen) begin
            hold_seen = hold_trig;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stalls_on && stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            if (stalls_on) stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(logic kind, logic [SAMPLE_W-1:0] smp);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_sample   <= smp;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        expected_beats.push_back(predict_beat(kind, smp));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [ENERGY_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        case (idx)
            bdeo_pkg::CFG_PEAK_THR:  thr_reg       = data[THR_W-1:0];
            bdeo_pkg::CFG_NOISE:     noise_reg     = data;
            bdeo_pkg::CFG_REFRACT:   refract_reg   = data[REFR_W-1:0];
            bdeo_pkg::CFG_MIN_VOTES: min_votes_reg = data[MINV_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_regs(int thr, int noise, int refr, int minv);
        cfg_put(bdeo_pkg::CFG_PEAK_THR, ENERGY_W'(thr));
        cfg_put(bdeo_pkg::CFG_NOISE, ENERGY_W'(noise));
        cfg_put(bdeo_pkg::CFG_REFRACT, ENERGY_W'(refr));
        cfg_put(bdeo_pkg::CFG_MIN_VOTES, ENERGY_W'(minv));
        i_cfg_valid <= 1'b0;
    endtask

    // alternating bursts and quiet stretches, with some clears and raw noise
    task automatic next_stream_item(output logic kind, output logic [SAMPLE_W-1:0] smp);
        int r;
        int mag;
        if (seg_left == 0) begin
            in_burst = !in_burst;
            seg_left = in_burst ? $urandom_range(4, 14) : $urandom_range(3, 20);
        end
        seg_left--;
        r    = $urandom_range(99);
        kind = bdeo_pkg::KIND_SAMPLE;
        mag  = in_burst ? $urandom_range(1500, 32768) : $urandom_range(0, 60);
        if ($urandom_range(1)) mag = -mag;
        smp = mag[SAMPLE_W-1:0];
        if (r < 3) begin
            kind = bdeo_pkg::KIND_CLEAR;
            smp  = SAMPLE_W'($urandom_range(16'hFFFF));
        end else if (r < 10) begin
            smp = SAMPLE_W'($urandom_range(16'hFFFF));
        end
    endtask

    task automatic test_directed();
        send_item(bdeo_pkg::KIND_SAMPLE, 16'sd32767);
        send_item(bdeo_pkg::KIND_SAMPLE, 16'h8000);
        send_item(bdeo_pkg::KIND_SAMPLE, 16'sd32767);
        send_item(bdeo_pkg::KIND_SAMPLE, 16'h8000);
        send_item(bdeo_pkg::KIND_SAMPLE, 16'sd0);
        send_item(bdeo_pkg::KIND_SAMPLE, -16'sd1);
        send_item(bdeo_pkg::KIND_CLEAR, 16'h5A5A);
        wait_drained();
        // one vote is enough, no refractory delay
        write_regs(1000, 2000, 0, 0);
        send_item(bdeo_pkg::KIND_SAMPLE, 16'sd5000);
        send_item(bdeo_pkg::KIND_SAMPLE, -16'sd5000);
        send_item(bdeo_pkg::KIND_SAMPLE, 16'sd5000);
        send_item(bdeo_pkg::KIND_SAMPLE, -16'sd5000);
        send_item(bdeo_pkg::KIND_SAMPLE, 16'sd5000);
        repeat (7) send_item(bdeo_pkg::KIND_SAMPLE, 16'sd0);
        send_item(bdeo_pkg::KIND_CLEAR, 16'hFFFF);
        send_item(bdeo_pkg::KIND_SAMPLE, 16'sd3000);
        send_item(bdeo_pkg::KIND_SAMPLE, 16'sd0);
        wait_drained();
    endtask

    task automatic test_random();
        logic                kind;
        logic [SAMPLE_W-1:0] smp;
        for (int ph = 0; ph < 8; ph++) begin
            wait_drained();
            case (ph)
                0:       write_regs(32768, 491520, 1023, 6);
                1:       write_regs(0, 0, 0, 0);
                default: write_regs($urandom_range(200, 4000), $urandom_range(300, 30000),
                                    $urandom_range(0, 12), $urandom_range(0, 5));
            endcase
            gaps_on   = (ph % 3 != 2);
            stalls_on = (ph % 4 != 3);
            repeat (RANDOM_ITEMS) begin
                next_stream_item(kind, smp);
                send_item(kind, smp);
            end
        end
        wait_drained();
    endtask

    task automatic test_pressure();
        logic                kind;
        logic [SAMPLE_W-1:0] smp;
        write_regs(800, 1500, 2, 3);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        hold_trig++;
        repeat (40) begin
            next_stream_item(kind, smp);
            send_item(kind, smp);
        end
        // sender pauses until the block has emptied
        wait_drained();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        repeat (30) begin
            next_stream_item(kind, smp);
            send_item(kind, smp);
        end
        wait_drained();
    endtask

    // no votes possible, then every nonzero sample votes under a long refractory delay
    task automatic test_no_votes();
        logic                kind;
        logic [SAMPLE_W-1:0] smp;
        write_regs(32768, bdeo_pkg::RST_NOISE, 0, 6);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        repeat (QUIET_RUN_ITEMS) begin
            smp = SAMPLE_W'($urandom_range(16'hFFFF));
            send_item(bdeo_pkg::KIND_SAMPLE, smp);
        end
        wait_drained();
        write_regs(0, 4000, 1023, 0);
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        repeat (30) begin
            next_stream_item(kind, smp);
            send_item(kind, smp);
        end
        wait_drained();
    endtask

    initial begin
        reset_shadow();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_pressure();
        test_no_votes();
        wait_drained();
        if (fail_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
